// ===== hw/rtl/terrain_height_sampler_assert.svh =====
// Assertion macros shared by the sampler's RTL files.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef TERRAIN_HEIGHT_SAMPLER_ASSERT_SVH
`define TERRAIN_HEIGHT_SAMPLER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define THS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define THS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ths_pkg.sv =====
`default_nettype none
package ths_pkg;

  localparam int GRID_DIM_DEF = 128;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [15:0] SCALE_RESET = 16'd256;

  // Divider geometry: a 31-bit position shifted left by 8, over a 16-bit scale.
  localparam int DIV_BITS = 39;
  localparam int REM_BITS = 17;
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // One queued item after classification.
  typedef struct packed {
    logic        is_write;
    logic        wr_ok;
    logic [6:0]  wx;
    logic [6:0]  wz;
    logic [15:0] wdata;
    logic        bad;
    logic [30:0] px;
    logic [30:0] pz;
  } ths_item_t;

  // Item state that rides along the divider pipeline.
  typedef struct packed {
    logic        valid;
    logic        is_write;
    logic        wr_ok;
    logic [6:0]  wx;
    logic [6:0]  wz;
    logic [15:0] wdata;
    logic        bad;
  } ths_meta_t;

  // Item state behind the grid lookup.
  typedef struct packed {
    logic valid;
    logic zero;
    logic oor;
  } ths_tail_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } ths_qstat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ths_front.sv =====
`default_nettype none
module ths_front #(
  parameter int GRID_DIM = ths_pkg::GRID_DIM_DEF
) (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [6:0]         cell_x,
  input  wire logic [6:0]         cell_z,
  input  wire logic signed [15:0] height_in,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [15:0]        cell_scale,
  input  wire ths_pkg::ths_qstat_t qstat,
  output logic                    push,
  output ths_pkg::ths_item_t      item
);
  import ths_pkg::*;

  // Accept whenever the queue has room.
  assign in_stall = qstat.full;
  assign push = in_valid && !qstat.full;

  // Classify the item: writes inside the grid, samples that can never hit it.
  always_comb begin
    item.is_write = !cmd;
    item.wr_ok = ({4'b0, cell_x} < 11'(GRID_DIM)) && ({4'b0, cell_z} < 11'(GRID_DIM));
    item.wx = cell_x;
    item.wz = cell_z;
    item.wdata = height_in;
    item.bad = pos_x[31] || pos_z[31] || (cell_scale == 16'd0);
    item.px = pos_x[30:0];
    item.pz = pos_z[30:0];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ths_queue.sv =====
`default_nettype none
`include "terrain_height_sampler_assert.svh"
module ths_queue #(
  parameter int DEPTH = ths_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ths_pkg::ths_item_t  push_item,
  input  wire logic                pop,
  output ths_pkg::ths_item_t       head,
  output ths_pkg::ths_qstat_t      qstat
);
  import ths_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ths_item_t     slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign qstat.full = (count == (PW+1)'(DEPTH));
  assign qstat.empty = (count == '0);
  assign head = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `THS_ASSERT(a_count_bound, count <= (PW+1)'(DEPTH), "queue count beyond depth")
  `THS_ASSERT_IMPL(a_pop_nonempty, pop, count != '0, "pop from empty queue")

endmodule
`default_nettype wire

// ===== hw/rtl/ths_div.sv =====
`default_nettype none
module ths_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [ths_pkg::DIV_BITS-1:0] dividend,
  input  wire logic [15:0]                  divisor,
  output logic [ths_pkg::DIV_BITS-1:0]      quotient
);
  import ths_pkg::*;

  localparam int SW = REM_BITS + DIV_BITS;

  // Each stage holds {partial remainder, remaining dividend and quotient bits}.
  logic [SW-1:0] stg [DIV_BITS];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
    logic [SW-1:0]       prev;
    logic [SW-1:0]       shifted;
    logic [REM_BITS-1:0] top;
    logic [SW-1:0]       nxt;

    if (i == 0) begin : g_first
      assign prev = {{REM_BITS{1'b0}}, dividend};
    end else begin : g_rest
      assign prev = stg[i-1];
    end

    // One restoring step: shift in a bit, subtract the divisor if it fits.
    always_comb begin
      shifted = {prev[SW-2:0], 1'b0};
      top = shifted[SW-1:DIV_BITS];
      nxt = shifted;
      if (top >= {1'b0, divisor}) begin
        nxt[SW-1:DIV_BITS] = top - {1'b0, divisor};
        nxt[0] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[i] <= nxt;
      end
    end
  end

  assign quotient = stg[DIV_BITS-1][DIV_BITS-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/ths_back.sv =====
`default_nettype none
`include "terrain_height_sampler_assert.svh"
module ths_back #(
  parameter int GRID_DIM = ths_pkg::GRID_DIM_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [15:0]         cell_scale,
  input  wire ths_pkg::ths_qstat_t qstat,
  input  wire ths_pkg::ths_item_t  head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       height,
  output logic                     out_of_range
);
  import ths_pkg::*;

  localparam int CW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int HW = (CW > 1) ? CW - 1 : 1;
  localparam int AW = 2 * HW;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int TXW = DIV_BITS - FRAC_BITS;

  logic en;

  // The whole pipeline advances unless a finished result is held.
  assign en = !(out_valid && out_stall);
  assign pop = en && !qstat.empty;

  // Divider pipelines and the item state alongside them.
  logic [DIV_BITS-1:0] qx;
  logic [DIV_BITS-1:0] qz;
  ths_meta_t meta [DIV_BITS];
  ths_meta_t meta_in;

  ths_div u_div_x (
    .clk      (clk),
    .en       (en),
    .dividend ({head.px, 8'b0}),
    .divisor  (cell_scale),
    .quotient (qx)
  );

  ths_div u_div_z (
    .clk      (clk),
    .en       (en),
    .dividend ({head.pz, 8'b0}),
    .divisor  (cell_scale),
    .quotient (qz)
  );

  always_comb begin
    meta_in.valid = pop;
    meta_in.is_write = head.is_write;
    meta_in.wr_ok = head.wr_ok;
    meta_in.wx = head.wx;
    meta_in.wz = head.wz;
    meta_in.wdata = head.wdata;
    meta_in.bad = head.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_BITS; i++) begin
        meta[i] <= '0;
      end
    end else if (en) begin
      meta[0] <= meta_in;
      for (int i = 1; i < DIV_BITS; i++) begin
        meta[i] <= meta[i-1];
      end
    end
  end

  // Cell index, fraction, range check and per-bank addresses.
  ths_meta_t         mq;
  logic [TXW-1:0]    tx;
  logic [TXW-1:0]    tz;
  logic              range_bad;
  logic [AW-1:0]     addr_c [4];
  logic [10:0]       wxe;
  logic [10:0]       wze;

  assign mq = meta[DIV_BITS-1];
  assign tx = qx[DIV_BITS-1:FRAC_BITS];
  assign tz = qz[DIV_BITS-1:FRAC_BITS];
  assign range_bad = (tx >= TXW'(GRID_DIM - 1)) || (tz >= TXW'(GRID_DIM - 1));

  always_comb begin
    logic [CW:0] xb;
    logic [CW:0] zb;
    for (int b = 0; b < 4; b++) begin
      xb = {1'b0, tx[CW-1:0]} + (CW+1)'(tx[0] ^ b[1]);
      zb = {1'b0, tz[CW-1:0]} + (CW+1)'(tz[0] ^ b[0]);
      addr_c[b] = {xb[HW:1], zb[HW:1]};
    end
  end

  logic              a_valid;
  logic              a_wr;
  logic              a_zero;
  logic              a_oor;
  logic [1:0]        a_wbank;
  logic [AW-1:0]     a_waddr;
  logic [15:0]       a_wdata;
  logic [AW-1:0]     a_addr [4];
  logic [1:0]        a_t0;
  logic [15:0]       a_fx;
  logic [15:0]       a_fz;

  assign wxe = {4'b0, mq.wx};
  assign wze = {4'b0, mq.wz};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= mq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_wr <= mq.is_write && mq.wr_ok;
      a_oor <= !mq.is_write && (mq.bad || range_bad);
      a_zero <= mq.is_write || mq.bad || range_bad;
      a_wbank <= {wxe[0], wze[0]};
      a_waddr <= {wxe[HW:1], wze[HW:1]};
      a_wdata <= mq.wdata;
      a_t0 <= {tx[0], tz[0]};
      a_fx <= qx[FRAC_BITS-1:0];
      a_fz <= qz[FRAC_BITS-1:0];
      for (int b = 0; b < 4; b++) begin
        a_addr[b] <= addr_c[b];
      end
    end
  end

  // Four grid banks split by the parity of column and row.
  wire [15:0] bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [15:0] mem [BANK_DEPTH];
    logic [15:0] rd;

    always_ff @(posedge clk) begin
      if (en && a_valid && a_wr && (a_wbank == 2'(b))) begin
        mem[a_waddr] <= a_wdata;
      end
      if (en) begin
        rd <= mem[a_addr[b]];
      end
    end

    assign bank_q[b] = rd;
  end

  // Sideband behind the lookup.
  ths_tail_t tail [6];
  ths_tail_t tail_in;

  always_comb begin
    tail_in.valid = a_valid;
    tail_in.zero = a_zero;
    tail_in.oor = a_oor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        tail[i] <= '0;
      end
    end else if (en) begin
      tail[0] <= tail_in;
      for (int i = 1; i < 6; i++) begin
        tail[i] <= tail[i-1];
      end
    end
  end

  logic [1:0]  m_t0;
  logic [15:0] m_fx;
  logic [15:0] m_fz;

  always_ff @(posedge clk) begin
    if (en) begin
      m_t0 <= a_t0;
      m_fx <= a_fx;
      m_fz <= a_fz;
    end
  end

  // Corner routing, triangle case and operand selection.
  logic signed [15:0] h00, h10, h01, h11;
  logic signed [15:0] z1s [4];
  logic signed [15:0] z2s [4];
  logic signed [15:0] z3s [4];
  logic [16:0]        wa [4];
  logic [16:0]        wb [4];
  logic [16:0]        fsum;
  logic [16:0]        fxo;
  logic [16:0]        fzo;
  logic [1:0]         kase;
  logic [1:0]         kase_b;

  assign h00 = bank_q[{m_t0[1], m_t0[0]}];
  assign h10 = bank_q[{~m_t0[1], m_t0[0]}];
  assign h01 = bank_q[{m_t0[1], ~m_t0[0]}];
  assign h11 = bank_q[{~m_t0[1], ~m_t0[0]}];
  assign fsum = {1'b0, m_fx} + {1'b0, m_fz};
  assign fxo = FRAC_ONE - {1'b0, m_fx};
  assign fzo = FRAC_ONE - {1'b0, m_fz};

  always_comb begin
    z3s[0] = h01; z1s[0] = h00; z2s[0] = h10; wa[0] = {1'b0, m_fx}; wb[0] = {1'b0, m_fz};
    z3s[1] = h00; z1s[1] = h10; z2s[1] = h11; wa[1] = {1'b0, m_fz}; wb[1] = fxo;
    z3s[2] = h10; z1s[2] = h11; z2s[2] = h01; wa[2] = fxo;          wb[2] = fzo;
    z3s[3] = h11; z1s[3] = h01; z2s[3] = h00; wa[3] = fzo;          wb[3] = {1'b0, m_fx};
    if (m_fx > m_fz) begin
      kase = (fsum <= FRAC_ONE) ? 2'd0 : 2'd1;
    end else begin
      kase = (fsum > FRAC_ONE) ? 2'd2 : 2'd3;
    end
    kase_b = kase + 2'd1;
  end

  // Per triangle: base corner, two corner differences, two weights.
  logic signed [15:0] s_z1 [2];
  logic signed [16:0] s_d2 [2];
  logic signed [16:0] s_d3 [2];
  logic [16:0]        s_a [2];
  logic [16:0]        s_b [2];

  always_ff @(posedge clk) begin
    if (en) begin
      s_z1[0] <= z1s[kase];
      s_d2[0] <= 17'(z2s[kase]) - 17'(z1s[kase]);
      s_d3[0] <= 17'(z3s[kase]) - 17'(z1s[kase]);
      s_a[0] <= wa[kase];
      s_b[0] <= wb[kase];
      s_z1[1] <= z1s[kase_b];
      s_d2[1] <= 17'(z2s[kase_b]) - 17'(z1s[kase_b]);
      s_d3[1] <= 17'(z3s[kase_b]) - 17'(z1s[kase_b]);
      s_a[1] <= wa[kase_b];
      s_b[1] <= wb[kase_b];
    end
  end

  // Weight products.
  logic signed [31:0] p_base [2];
  logic signed [34:0] p_2 [2];
  logic signed [34:0] p_3 [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 2; t++) begin
        p_base[t] <= {s_z1[t], 16'b0};
        p_2[t] <= s_d2[t] * $signed({1'b0, s_a[t]});
        p_3[t] <= s_d3[t] * $signed({1'b0, s_b[t]});
      end
    end
  end

  // Triangle sums in Q.24.
  logic signed [35:0] t_sum [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 2; t++) begin
        t_sum[t] <= 36'(p_base[t]) + 36'(p_2[t]) + 36'(p_3[t]);
      end
    end
  end

  // Larger of the two; a blend of Q8.8 heights fits 32 bits.
  logic signed [31:0] best;

  always_ff @(posedge clk) begin
    if (en) begin
      best <= (t_sum[0] > t_sum[1]) ? t_sum[0][31:0] : t_sum[1][31:0];
    end
  end

  // Scale multiply.
  logic signed [48:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= best * $signed({1'b0, cell_scale});
    end
  end

  // Floor shift, saturation and the result register.
  logic signed [32:0] shifted;
  logic signed [31:0] sat;

  assign shifted = prod[48:16];

  always_comb begin
    if (shifted[32] != shifted[31]) begin
      sat = shifted[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      sat = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail[5].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      height <= tail[5].zero ? 32'sd0 : sat;
      out_of_range <= tail[5].oor;
    end
  end

  `THS_ASSERT_IMPL(a_oor_zero, out_valid && out_of_range, height == 32'sd0,
                   "out-of-range result with nonzero height")

endmodule
`default_nettype wire

// ===== hw/rtl/terrain_height_sampler.sv =====
`default_nettype none
// Terrain height sampler. Write items (cmd 0) load one signed Q8.8 height into
// a GRID_DIM x GRID_DIM grid; sample items (cmd 1) return the interpolated
// height at a Q16.16 world position, scaled by cell_scale and saturated. Every
// item gives exactly one result, in order; writes return height 0. The block
// takes one item per clock while the output is not stalled. Each result passes
// the queue, a 39-stage one-bit-per-stage divider per axis, then the grid
// lookup, two triangle blends, the scale multiply and the output register. The
// grid sits in four banks split by column and row parity, so all four corners
// of a cell are read in the same cycle. Grid contents are undefined after reset
// and there is no clearing pass; sample only written cells. Write cell_scale
// only while the block is idle.
module terrain_height_sampler #(
  parameter int GRID_DIM = ths_pkg::GRID_DIM_DEF,
  parameter int QUEUE_DEPTH = ths_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [6:0]         cell_x,
  input  wire logic [6:0]         cell_z,
  input  wire logic signed [15:0] height_in,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      height,
  output logic                    out_of_range
);
  import ths_pkg::*;

  logic [15:0] cell_scale;
  ths_qstat_t  qstat;
  ths_item_t   push_item;
  ths_item_t   head;
  logic        push;
  logic        pop;

  // Scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      cell_scale <= cfg_wdata;
    end
  end

  ths_front #(.GRID_DIM(GRID_DIM)) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .cell_x     (cell_x),
    .cell_z     (cell_z),
    .height_in  (height_in),
    .pos_x      (pos_x),
    .pos_z      (pos_z),
    .cell_scale (cell_scale),
    .qstat      (qstat),
    .push       (push),
    .item       (push_item)
  );

  ths_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ths_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cell_scale   (cell_scale),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .height       (height),
    .out_of_range (out_of_range)
  );

endmodule
`default_nettype wire

// ===== bench/tb_terrain_height_sampler.sv =====
`timescale 1ns / 1ps

module tb_terrain_height_sampler;

  localparam int GRID = 128;
  localparam int FRAC_ONE_I = 65536;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  cx;
    logic [6:0]  cz;
    logic [15:0] h;
    logic [31:0] px;
    logic [31:0] pz;
  } grid_item_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               oor;
  } height_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic [6:0] cell_x = '0;
  logic [6:0] cell_z = '0;
  logic signed [15:0] height_in = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] height;
  logic out_of_range;

  terrain_height_sampler DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .cell_x(cell_x),
    .cell_z(cell_z), .height_in(height_in), .pos_x(pos_x), .pos_z(pos_z),
    .out_valid(out_valid), .out_stall(out_stall), .height(height),
    .out_of_range(out_of_range)
  );

  // Pending stimulus, expected heights, and the predictor's grid copy.
  grid_item_t pending_q[$];
  height_result_t height_expect_q[$];
  logic [15:0] model_grid [0:GRID*GRID-1];
  logic [15:0] model_scale = 16'd256;
  bit planned_written [0:GRID*GRID-1];
  logic [15:0] plan_scale = 16'd256;
  int send_idle = 30;
  int recv_idle = 47;
  int err_count = 0;
  int cycle_count = 0;
  logic in_took = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Grid coordinate in Q.16 for one axis.
  function automatic longint unsigned grid_coord(logic [31:0] p, logic [15:0] sc);
    longint unsigned num;
    num = {32'd0, p} << 8;
    return num / sc;
  endfunction

  // One planar blend in Q.24; a full second weight lands on the third corner.
  function automatic longint blend_tri(longint z3, longint z1, longint z2,
                                       longint a, longint b);
    if (b == FRAC_ONE_I) return z3 * FRAC_ONE_I;
    return z1 * (FRAC_ONE_I - a - b) + z2 * a + z3 * b;
  endfunction

  function automatic longint corner(longint x, longint z);
    logic signed [15:0] raw;
    raw = model_grid[x * GRID + z];
    return longint'(raw);
  endfunction

  function automatic height_result_t predict_height(grid_item_t it);
    height_result_t r;
    longint unsigned ux, uz;
    longint tx, tz, fx, fz, h00, h10, h01, h11, p, q, best, prod;
    r.height = '0;
    r.oor = 1'b0;
    if (it.cmd == CMD_WRITE) begin
      model_grid[it.cx * GRID + it.cz] = it.h;
      return r;
    end
    if (it.px[31] || it.pz[31] || model_scale == 0) begin
      r.oor = 1'b1;
      return r;
    end
    ux = grid_coord(it.px, model_scale);
    uz = grid_coord(it.pz, model_scale);
    tx = longint'(ux >> 16);
    tz = longint'(uz >> 16);
    if (tx + 1 >= GRID || tz + 1 >= GRID) begin
      r.oor = 1'b1;
      return r;
    end
    fx = longint'(ux & 64'hFFFF);
    fz = longint'(uz & 64'hFFFF);
    h00 = corner(tx, tz);
    h10 = corner(tx + 1, tz);
    h01 = corner(tx, tz + 1);
    h11 = corner(tx + 1, tz + 1);
    // Pick the triangle pair from the fraction sum and the fraction order.
    if (fx + fz <= FRAC_ONE_I && fx > fz) begin
      p = blend_tri(h01, h00, h10, fx, fz);
      q = blend_tri(h00, h10, h11, fz, FRAC_ONE_I - fx);
    end else if (fx + fz > FRAC_ONE_I && fx > fz) begin
      p = blend_tri(h00, h10, h11, fz, FRAC_ONE_I - fx);
      q = blend_tri(h10, h11, h01, FRAC_ONE_I - fx, FRAC_ONE_I - fz);
    end else if (fx + fz > FRAC_ONE_I) begin
      p = blend_tri(h10, h11, h01, FRAC_ONE_I - fx, FRAC_ONE_I - fz);
      q = blend_tri(h11, h01, h00, FRAC_ONE_I - fz, fx);
    end else begin
      p = blend_tri(h11, h01, h00, FRAC_ONE_I - fz, fx);
      q = blend_tri(h01, h00, h10, fx, fz);
    end
    best = (p > q) ? p : q;
    prod = (best * longint'({16'd0, model_scale})) >>> 16;
    if (prod > 64'sd2147483647) prod = 64'sd2147483647;
    if (prod < -64'sd2147483648) prod = -64'sd2147483648;
    r.height = prod[31:0];
    return r;
  endfunction

  // Monitor: transfers in and out, configuration tracking, and the time limit.
  always @(posedge clk) begin
    height_result_t got, want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (cfg_we) model_scale = cfg_wdata;
      if (in_valid && !in_stall) begin
        height_expect_q.push_back(predict_height({cmd, cell_x, cell_z, height_in,
                                                  pos_x, pos_z}));
      end
      if (out_valid && !out_stall) begin
        got.height = height;
        got.oor = out_of_range;
        if (height_expect_q.size() == 0) begin
          $error("result transfer with no expected result");
          err_count++;
        end else begin
          want = height_expect_q.pop_front();
          if (got.height !== want.height) begin
            $error("height: expected %0d, actual %0d", want.height, got.height);
            err_count++;
          end
          if (got.oor !== want.oor) begin
            $error("out_of_range: expected %0b, actual %0b", want.oor, got.oor);
            err_count++;
          end
        end
      end
    end
  end

  // Driver: randomly stalls the output and presents the next pending item once the previous one transferred.
  always @(negedge clk) begin
    grid_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
      if (!in_valid || in_took) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          it = pending_q.pop_front();
          cmd <= it.cmd;
          cell_x <= it.cx;
          cell_z <= it.cz;
          height_in <= it.h;
          pos_x <= it.px;
          pos_z <= it.pz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_write(int x, int z, logic [15:0] h);
    grid_item_t it;
    it.cmd = CMD_WRITE;
    it.cx = x[6:0];
    it.cz = z[6:0];
    it.h = h;
    it.px = $urandom();
    it.pz = $urandom();
    planned_written[x * GRID + z] = 1'b1;
    pending_q.push_back(it);
  endtask

  function automatic logic [15:0] rand_height();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Queues a sample, first loading any of its four corners not yet written.
  task automatic push_sample(logic [31:0] px, logic [31:0] pz);
    grid_item_t it;
    longint tx, tz;
    if (!px[31] && !pz[31] && plan_scale != 0) begin
      tx = longint'(grid_coord(px, plan_scale) >> 16);
      tz = longint'(grid_coord(pz, plan_scale) >> 16);
      if (tx + 1 < GRID && tz + 1 < GRID) begin
        for (int dx = 0; dx < 2; dx++) begin
          for (int dz = 0; dz < 2; dz++) begin
            if (!planned_written[(tx + dx) * GRID + tz + dz])
              push_write(int'(tx) + dx, int'(tz) + dz, rand_height());
          end
        end
      end
    end
    it.cmd = CMD_SAMPLE;
    it.cx = 7'($urandom());
    it.cz = 7'($urandom());
    it.h = 16'($urandom());
    it.px = px;
    it.pz = pz;
    pending_q.push_back(it);
  endtask

  // World position that lands on grid coordinate t.f under the planned scale.
  function automatic logic [31:0] world_pos(int t, int f);
    longint unsigned u;
    u = (longint'(t) << 16) | longint'(f);
    return 32'((u * plan_scale) >> 8);
  endfunction

  function automatic int rand_frac();
    case ($urandom_range(7))
      0: return 0;
      1: return 65535;
      2: return 32768;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || height_expect_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_scale(logic [15:0] sc);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sc;
    plan_scale = sc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int count);
    int t1, t2;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: push_write($urandom_range(GRID - 1), $urandom_range(GRID - 1), rand_height());
        1, 2: push_sample($urandom(), $urandom());
        default: begin
          // Well-formed sample, mostly in a small corner of the grid.
          if ($urandom_range(9) == 0) begin
            t1 = $urandom_range(GRID - 2);
            t2 = $urandom_range(GRID - 2);
          end else begin
            t1 = $urandom_range(15);
            t2 = $urandom_range(15);
          end
          push_sample(world_pos(t1, rand_frac()), world_pos(t2, rand_frac()));
        end
      endcase
    end
  endtask

  initial begin
    logic [15:0] scales [6];
    scales = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd128, 16'd1000};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset scale: height extremes and every triangle case.
    set_scale(16'd256);
    push_write(0, 0, 16'h7FFF);
    push_write(1, 0, 16'h8000);
    push_write(0, 1, 16'h0000);
    push_write(1, 1, 16'hFFFF);
    push_write(127, 127, 16'h8000);
    push_write(127, 127, 16'h7FFF);
    push_sample(32'd0, 32'd0);
    push_sample(world_pos(0, 40000), world_pos(0, 10000));
    push_sample(world_pos(0, 60000), world_pos(0, 30000));
    push_sample(world_pos(0, 30000), world_pos(0, 60000));
    push_sample(world_pos(0, 10000), world_pos(0, 20000));
    push_sample(world_pos(0, 65535), world_pos(0, 65535));
    push_sample(world_pos(0, 32768), world_pos(0, 32768));
    push_sample(world_pos(126, 65535), world_pos(126, 1));
    push_sample(32'h8000_0000, 32'd0);
    push_sample(32'd0, 32'hFFFF_FFFF);
    push_sample(world_pos(127, 0), 32'd0);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // Random part over several scales and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      set_scale(ph == 5 ? 16'($urandom_range(2, 65535)) : scales[ph]);
      if (ph < 2) begin
        send_idle = 30;
        recv_idle = 47;
      end else if (ph < 4) begin
        send_idle = 47;
        recv_idle = 30;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_items(ph == 3 ? 100 : 180);
    end

    wait_drained();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ths_pkg.sv
hw/rtl/ths_front.sv
hw/rtl/ths_queue.sv
hw/rtl/ths_div.sv
hw/rtl/ths_back.sv
hw/rtl/terrain_height_sampler.sv
bench/tb_terrain_height_sampler.sv
